[hw/rtl/kotsl_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kotsl_pkg
// Types, codes and the control store for the k-th of two sorted lists block.
// ----------------------------------------------------------------------------
package kotsl_pkg;

    localparam int ACTION_W  = 2;
    localparam int VALUE_W   = 32;
    localparam int RANK_W    = 12;
    localparam int ELEMENT_W = 32;

    localparam logic [ACTION_W-1:0] ACT_LOAD_FIRST  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD_SECOND = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY       = 2'd2;

    localparam logic signed [ELEMENT_W-1:0] ELEMENT_NONE = -32'sd1;

    typedef struct packed {
        logic [ACTION_W-1:0]       action;
        logic signed [VALUE_W-1:0] value;
        logic [RANK_W-1:0]         rank;
    } in_item_t;

    typedef struct packed {
        logic                        found;
        logic signed [ELEMENT_W-1:0] element;
        logic                        overflow;
    } out_item_t;

    typedef enum logic [1:0] {
        STEP_IDLE,
        STEP_CHECK,
        STEP_WALK,
        STEP_EMIT
    } step_t;

    typedef enum logic [1:0] {
        COND_QUERY,
        COND_BAD_RANK,
        COND_MORE,
        COND_OUT_FREE
    } cond_t;

    typedef struct packed {
        logic accept_en;
        logic check_en;
        logic walk_en;
        logic emit_en;
    } ctrl_t;

    typedef struct packed {
        logic query;
        logic bad_rank;
        logic more;
        logic out_free;
    } status_t;

    typedef struct packed {
        ctrl_t ctrl;
        cond_t cond;
        step_t on_true;
        step_t on_false;
    } uword_t;

    // control store
    function automatic uword_t urom(step_t s);
        uword_t w;
        unique case (s)
            STEP_IDLE:  w = '{ctrl: '{1'b1, 1'b0, 1'b0, 1'b0}, cond: COND_QUERY,
                              on_true: STEP_CHECK, on_false: STEP_IDLE};
            STEP_CHECK: w = '{ctrl: '{1'b0, 1'b1, 1'b0, 1'b0}, cond: COND_BAD_RANK,
                              on_true: STEP_EMIT, on_false: STEP_WALK};
            STEP_WALK:  w = '{ctrl: '{1'b0, 1'b0, 1'b1, 1'b0}, cond: COND_MORE,
                              on_true: STEP_WALK, on_false: STEP_EMIT};
            STEP_EMIT:  w = '{ctrl: '{1'b0, 1'b0, 1'b0, 1'b1}, cond: COND_OUT_FREE,
                              on_true: STEP_IDLE, on_false: STEP_EMIT};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/kth_of_two_sorted_lists.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kth_of_two_sorted_lists
// k-th smallest element of two ascending lists, found by a merge walk.
// ----------------------------------------------------------------------------
// A load item (action 0 or 1) appends its value to the chosen list; loads
// into a full list are dropped and flagged in the next result. A query item
// (action 2) returns one result and blocks input while it runs: a range check
// step, then, when the rank is valid, a walk step over k elements (the merge
// loop takes one element a cycle, limited by the single registered read port
// of each list store), then an emit step that loads the output register once
// it is free. The next item is taken the cycle after that load. Both stores
// are emptied by the query, through their fill counts; no clearing pass is
// needed after reset. Action 3 is ignored.
// ----------------------------------------------------------------------------
module kth_of_two_sorted_lists #(
    parameter int LIST_DEPTH = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire kotsl_pkg::in_item_t  s_item,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output kotsl_pkg::out_item_t      m_item
);
    import kotsl_pkg::*;

    localparam int CW    = $clog2(LIST_DEPTH + 1);
    localparam int IW    = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int SUM_W = ((CW + 1) > RANK_W) ? (CW + 1) : RANK_W;

    ctrl_t   ctrl;
    step_t   step;
    status_t status;

    logic accepted;
    logic load_a;
    logic load_b;
    logic query_acc;
    logic emit_fire;

    logic signed [63:0]           value_wide;
    logic signed [DATA_WIDTH-1:0] wr_data;

    logic [CW-1:0]                cnt_a;
    logic [CW-1:0]                cnt_b;
    logic                         full_a;
    logic                         full_b;
    logic signed [DATA_WIDTH-1:0] head_a;
    logic signed [DATA_WIDTH-1:0] head_b;

    logic [CW-1:0]                i_reg;
    logic [CW-1:0]                i_next;
    logic [CW-1:0]                j_reg;
    logic [CW-1:0]                j_next;
    logic [RANK_W-1:0]            c_reg;
    logic [RANK_W-1:0]            c_next;
    logic [RANK_W-1:0]            k_reg;
    logic signed [DATA_WIDTH-1:0] picked_reg;
    logic                         found_reg;
    logic                         dropped_reg;
    logic                         dropped_next;

    logic                         has_a;
    logic                         has_b;
    logic                         take_first;
    logic [SUM_W-1:0]             total;
    logic signed [63:0]           picked_wide;

    logic                         m_valid_reg;
    out_item_t                    m_item_reg;

    kotsl_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl),
        .step    (step)
    );

    assign s_ready   = ctrl.accept_en;
    assign accepted  = s_valid && s_ready;
    assign load_a    = accepted && (s_item.action == ACT_LOAD_FIRST);
    assign load_b    = accepted && (s_item.action == ACT_LOAD_SECOND);
    assign query_acc = accepted && (s_item.action == ACT_QUERY);
    assign emit_fire = ctrl.emit_en && status.out_free;

    assign value_wide = 64'(s_item.value);
    assign wr_data    = value_wide[DATA_WIDTH-1:0];

    kotsl_list #(
        .LIST_DEPTH (LIST_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_list_a (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (load_a),
        .wr_data (wr_data),
        .clear   (emit_fire),
        .rd_addr (i_next[IW-1:0]),
        .count   (cnt_a),
        .full    (full_a),
        .head    (head_a)
    );

    kotsl_list #(
        .LIST_DEPTH (LIST_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_list_b (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (load_b),
        .wr_data (wr_data),
        .clear   (emit_fire),
        .rd_addr (j_next[IW-1:0]),
        .count   (cnt_b),
        .full    (full_b),
        .head    (head_b)
    );

    // merge choice, ties go to the second list
    assign has_a      = (i_reg < cnt_a);
    assign has_b      = (j_reg < cnt_b);
    assign take_first = (has_a && has_b) ? (head_a < head_b) : has_a;
    assign total      = SUM_W'(cnt_a) + SUM_W'(cnt_b);

    always_comb begin
        status.query    = query_acc;
        status.bad_rank = (k_reg == '0) || (SUM_W'(k_reg) > total);
        status.more     = (RANK_W'(c_reg + 1'b1) != k_reg);
        status.out_free = !m_valid_reg || m_ready;
    end

    always_comb begin
        i_next = i_reg;
        j_next = j_reg;
        c_next = c_reg;
        if (query_acc) begin
            i_next = '0;
            j_next = '0;
            c_next = '0;
        end else if (ctrl.walk_en) begin
            c_next = c_reg + 1'b1;
            if (take_first) begin
                i_next = i_reg + 1'b1;
            end else begin
                j_next = j_reg + 1'b1;
            end
        end
    end

    always_comb begin
        dropped_next = dropped_reg;
        if (emit_fire) begin
            dropped_next = 1'b0;
        end else if ((load_a && full_a) || (load_b && full_b)) begin
            dropped_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            i_reg       <= '0;
            j_reg       <= '0;
            c_reg       <= '0;
            dropped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            i_reg       <= i_next;
            j_reg       <= j_next;
            c_reg       <= c_next;
            dropped_reg <= dropped_next;
            if (emit_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign picked_wide = 64'(picked_reg);

    always_ff @(posedge aclk) begin
        if (query_acc) begin
            k_reg <= s_item.rank;
        end
        if (ctrl.check_en) begin
            found_reg <= !status.bad_rank;
        end
        if (ctrl.walk_en) begin
            picked_reg <= take_first ? head_a : head_b;
        end
        if (emit_fire) begin
            m_item_reg.found    <= found_reg;
            m_item_reg.element  <= found_reg ? picked_wide[ELEMENT_W-1:0] : ELEMENT_NONE;
            m_item_reg.overflow <= dropped_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // the walk never steps past both lists
    a_walk_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.walk_en |-> (has_a || has_b))
        else $error("merge walk ran past both lists");

    // a query holds off input until its result is out
    a_query_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        query_acc |=> !s_ready)
        else $error("input taken during a query");

    // emitting a result empties both stores
    a_emit_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_fire |=> (m_valid && cnt_a == '0 && cnt_b == '0 && !dropped_reg))
        else $error("stores not emptied after a result");

    // a miss always carries the not-found value
    a_miss_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_item.found) |-> (m_item.element == ELEMENT_NONE))
        else $error("miss without the not-found value");

    // walking only happens in the walk step
    a_walk_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.walk_en |-> (step == STEP_WALK && !s_ready))
        else $error("walk outside its step");

endmodule
`default_nettype wire

[hw/rtl/kotsl_list.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kotsl_list
// One list store: append port with fill count, registered read of the head.
// ----------------------------------------------------------------------------
module kotsl_list #(
    parameter int LIST_DEPTH = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    wr_en,
    input  wire logic signed [DATA_WIDTH-1:0]            wr_data,
    input  wire logic                                    clear,
    input  wire logic [((LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1)-1:0] rd_addr,
    output logic [$clog2(LIST_DEPTH+1)-1:0]              count,
    output logic                                         full,
    output logic signed [DATA_WIDTH-1:0]                 head
);
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    logic signed [DATA_WIDTH-1:0] mem [LIST_DEPTH];
    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                count_next;
    logic signed [DATA_WIDTH-1:0] head_reg;

    assign full = (count_reg == CW'(LIST_DEPTH));

    always_comb begin
        count_next = count_reg;
        if (clear) begin
            count_next = '0;
        end else if (wr_en && !full) begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en && !full) begin
            mem[count_reg[IW-1:0]] <= wr_data;
        end
        head_reg <= mem[rd_addr];
    end

    assign count = count_reg;
    assign head  = head_reg;

endmodule
`default_nettype wire

[hw/rtl/kotsl_useq.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kotsl_useq
// Step counter and control store with two-way conditional branches.
// ----------------------------------------------------------------------------
module kotsl_useq (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire kotsl_pkg::status_t status,
    output kotsl_pkg::ctrl_t       ctrl,
    output kotsl_pkg::step_t       step
);
    import kotsl_pkg::*;

    step_t  step_reg;
    step_t  step_next;
    uword_t uword;
    logic   cond_hit;

    assign uword = urom(step_reg);

    always_comb begin
        unique case (uword.cond)
            COND_QUERY:    cond_hit = status.query;
            COND_BAD_RANK: cond_hit = status.bad_rank;
            COND_MORE:     cond_hit = status.more;
            COND_OUT_FREE: cond_hit = status.out_free;
        endcase
    end

    always_comb begin
        step_next = cond_hit ? uword.on_true : uword.on_false;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

    always_comb begin
        ctrl = uword.ctrl;
    end

    assign step = step_reg;

endmodule
`default_nettype wire
